>>> src/held_key_repeat_generator_defines.svh
// Assertion macros used by the held-key repeat generator checker.
`ifndef HELD_KEY_REPEAT_GENERATOR_DEFINES_SVH
`define HELD_KEY_REPEAT_GENERATOR_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define HKRG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define HKRG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/hkrg_pkg.sv
// Types and constants of the held-key repeat generator.
package hkrg_pkg;

  localparam int CODE_W    = 10;
  localparam int DEV_W     = 6;
  localparam int DLY_W     = 8;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 1;

  // Input function codes
  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PRESS  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'b1;

  localparam logic [DLY_W-1:0] DELAY_RESET    = 8'd15;
  localparam logic [DLY_W-1:0] INTERVAL_RESET = 8'd5;

  typedef struct packed {
    logic              func;
    logic [CODE_W-1:0] key_code;
    logic [DEV_W-1:0]  device_id;
    logic              key_press;
    logic              key_up;
    logic              is_repeat;
    logic              is_dpad;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] out_key_code;
    logic [DEV_W-1:0]  out_device_id;
    logic              last;
  } out_item_t;

  // Flags from the shared compare unit for the entry under scan
  typedef struct packed {
    logic passed;
    logic match;
    logic less;
  } cmp_res_t;

endpackage

>>> src/hkrg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hkrg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write one word, read one word a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/hkrg_unit.sv
// Shared compare and add unit applied to one table entry per cycle.
module hkrg_unit #(
  parameter int TIME_BITS = 32
) (
  input  logic [TIME_BITS-1:0]        now,
  input  logic [TIME_BITS-1:0]        trig,
  input  logic [hkrg_pkg::CODE_W-1:0] rd_code,
  input  logic [hkrg_pkg::CODE_W-1:0] ref_code,
  input  logic [hkrg_pkg::DLY_W-1:0]  step,
  output hkrg_pkg::cmp_res_t          res,
  output logic [TIME_BITS-1:0]        sum
);
  import hkrg_pkg::*;

  logic [TIME_BITS-1:0] diff;

  // Wrap-safe trigger check: difference nonzero and in the lower half
  assign diff       = now - trig;
  assign res.passed = (diff != '0) && !diff[TIME_BITS-1];

  // Key compare against the searched or best-so-far code
  assign res.match = (rd_code == ref_code);
  assign res.less  = (rd_code < ref_code);

  // Next trigger time
  assign sum = now + TIME_BITS'(step);

endmodule

>>> src/held_key_repeat_generator.sv
// Key event: one lookup pass over the table RAM, then its result.
// Tick: one pass over the table RAM to mark due entries, then one selection pass over the
//   table RAM for each repeat result, in ascending key order.
// One item at a time: the next start is taken only once the block is idle again, and busy
//   drops with the last result strobe, or without one if the item causes no result.
// Results are one-cycle strobes on out_strobe; the receiver cannot stall them.
// Reset (synchronous, rst_n low): table empty, time zero, delay 15 and interval 5 ticks.
module held_key_repeat_generator #(
  parameter int HELD_KEYS = 8,
  parameter int TIME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  hkrg_pkg::in_item_t             in_item,
  output logic                           out_strobe,
  output hkrg_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hkrg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hkrg_pkg::DLY_W-1:0]     cfg_data
);
  import hkrg_pkg::*;

  localparam int IDX_W  = (HELD_KEYS > 1) ? $clog2(HELD_KEYS) : 1;
  localparam int CNT_W  = $clog2(HELD_KEYS + 1);
  localparam int WORD_W = TIME_BITS + DEV_W + CODE_W;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(HELD_KEYS);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EV_SCAN = 3'd1;
  localparam logic [2:0] S_EV_DONE = 3'd2;
  localparam logic [2:0] S_TK_DUE  = 3'd3;
  localparam logic [2:0] S_TK_SEL  = 3'd4;
  localparam logic [2:0] S_TK_EMIT = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [DLY_W-1:0]     delay_r, delay_nxt;
  logic [DLY_W-1:0]     interval_r, interval_nxt;
  logic [HELD_KEYS-1:0] valid_r, valid_nxt;
  logic [HELD_KEYS-1:0] due_r, due_nxt;
  logic [CNT_W-1:0]     due_cnt_r, due_cnt_nxt;
  logic                 found_r, found_nxt;
  logic                 free_found_r, free_found_nxt;
  logic                 have_best_r, have_best_nxt;
  logic                 out_strobe_r, out_strobe_nxt;

  in_item_t             item_r, item_nxt;
  logic [IDX_W-1:0]     match_idx_r, match_idx_nxt;
  logic [IDX_W-1:0]     free_idx_r, free_idx_nxt;
  logic [CODE_W-1:0]    best_code_r, best_code_nxt;
  logic [DEV_W-1:0]     best_dev_r, best_dev_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  out_item_t            out_item_r, out_item_nxt;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [WORD_W-1:0]    ram_rdata;

  logic [CODE_W-1:0]    rd_code;
  logic [DEV_W-1:0]     rd_dev;
  logic [TIME_BITS-1:0] rd_trig;
  logic [CNT_W-1:0]     rd_cnt_m1;
  logic [IDX_W-1:0]     eval_idx;
  logic                 eval_on;
  logic                 press;

  cmp_res_t             unit_res;
  logic [CODE_W-1:0]    unit_ref;
  logic [DLY_W-1:0]     unit_step;
  logic [TIME_BITS-1:0] unit_sum;

  // Table of held keys: {trigger, device, code} per entry
  hkrg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (HELD_KEYS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Scan addressing: read entry rd_cnt, evaluate entry rd_cnt-1 from the registered read data
  assign ram_raddr = rd_cnt_r[IDX_W-1:0];
  assign rd_cnt_m1 = rd_cnt_r - CNT_W'(1);
  assign eval_idx  = rd_cnt_m1[IDX_W-1:0];
  assign eval_on   = (rd_cnt_r != '0);

  assign rd_code = ram_rdata[CODE_W-1:0];
  assign rd_dev  = ram_rdata[CODE_W +: DEV_W];
  assign rd_trig = ram_rdata[CODE_W + DEV_W +: TIME_BITS];

  assign press = item_r.key_press && !item_r.is_repeat && item_r.is_dpad;

  // Select the unit's operands for the current step
  assign unit_ref  = (state_r == S_TK_SEL) ? best_code_r : item_r.key_code;
  assign unit_step = (state_r == S_TK_EMIT) ? interval_r : delay_r;

  hkrg_unit #(
    .TIME_BITS (TIME_BITS)
  ) u_unit (
    .now      (now_r),
    .trig     (rd_trig),
    .rd_code  (rd_code),
    .ref_code (unit_ref),
    .step     (unit_step),
    .res      (unit_res),
    .sum      (unit_sum)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    rd_cnt_nxt     = rd_cnt_r;
    now_nxt        = now_r;
    delay_nxt      = delay_r;
    interval_nxt   = interval_r;
    valid_nxt      = valid_r;
    due_nxt        = due_r;
    due_cnt_nxt    = due_cnt_r;
    found_nxt      = found_r;
    free_found_nxt = free_found_r;
    have_best_nxt  = have_best_r;
    out_strobe_nxt = 1'b0;
    item_nxt       = item_r;
    match_idx_nxt  = match_idx_r;
    free_idx_nxt   = free_idx_r;
    best_code_nxt  = best_code_r;
    best_dev_nxt   = best_dev_r;
    best_idx_nxt   = best_idx_r;
    out_item_nxt   = out_item_r;
    ram_we         = 1'b0;
    ram_waddr      = free_idx_r;
    ram_wdata      = {unit_sum, item_r.device_id, item_r.key_code};

    // Take configuration writes
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_DELAY:    delay_nxt    = cfg_data;
        REG_INTERVAL: interval_nxt = cfg_data;
        default:      ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt   = in_item;
          rd_cnt_nxt = '0;
          if (in_item.func == FUNC_TICK) begin
            now_nxt     = now_r + TIME_BITS'(1);
            due_nxt     = '0;
            due_cnt_nxt = '0;
            state_nxt   = S_TK_DUE;
          end else begin
            found_nxt      = 1'b0;
            free_found_nxt = 1'b0;
            state_nxt      = S_EV_SCAN;
          end
        end
      end

      // Look up the key and the first free entry
      S_EV_SCAN: begin
        rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
        if (eval_on) begin
          if (valid_r[eval_idx] && unit_res.match) begin
            found_nxt     = 1'b1;
            match_idx_nxt = eval_idx;
          end
          if (!valid_r[eval_idx] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = eval_idx;
          end
        end
        if (rd_cnt_r == LAST_CNT) begin
          state_nxt = S_EV_DONE;
        end
      end

      // Enter, drop or release the key
      S_EV_DONE: begin
        state_nxt = S_IDLE;
        if (press) begin
          if (!found_r) begin
            out_strobe_nxt             = 1'b1;
            out_item_nxt.out_key_code  = item_r.key_code;
            out_item_nxt.out_device_id = item_r.device_id;
            out_item_nxt.last          = 1'b1;
            if (free_found_r) begin
              out_item_nxt.kind     = KIND_PRESS;
              ram_we                = 1'b1;
              valid_nxt[free_idx_r] = !item_r.key_up;
            end else begin
              out_item_nxt.kind = KIND_FULL;
            end
          end
        end else if (item_r.key_up && found_r) begin
          valid_nxt[match_idx_r] = 1'b0;
        end
      end

      // Mark every entry whose trigger has passed
      S_TK_DUE: begin
        rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
        if (eval_on && valid_r[eval_idx] && unit_res.passed) begin
          due_nxt[eval_idx] = 1'b1;
          due_cnt_nxt       = due_cnt_r + CNT_W'(1);
        end
        if (rd_cnt_r == LAST_CNT) begin
          rd_cnt_nxt    = '0;
          have_best_nxt = 1'b0;
          state_nxt     = (due_cnt_nxt == '0) ? S_IDLE : S_TK_SEL;
        end
      end

      // Find the lowest key code among the due entries
      S_TK_SEL: begin
        rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
        if (eval_on && due_r[eval_idx] && (!have_best_r || unit_res.less)) begin
          have_best_nxt = 1'b1;
          best_code_nxt = rd_code;
          best_dev_nxt  = rd_dev;
          best_idx_nxt  = eval_idx;
        end
        if (rd_cnt_r == LAST_CNT) begin
          state_nxt = S_TK_EMIT;
        end
      end

      // Issue the repeat and reschedule the entry
      S_TK_EMIT: begin
        out_strobe_nxt             = 1'b1;
        out_item_nxt.kind          = KIND_REPEAT;
        out_item_nxt.out_key_code  = best_code_r;
        out_item_nxt.out_device_id = best_dev_r;
        out_item_nxt.last          = (due_cnt_r == CNT_W'(1));
        ram_we                     = 1'b1;
        ram_waddr                  = best_idx_r;
        ram_wdata                  = {unit_sum, best_dev_r, best_code_r};
        due_nxt[best_idx_r]        = 1'b0;
        due_cnt_nxt                = due_cnt_r - CNT_W'(1);
        rd_cnt_nxt                 = '0;
        have_best_nxt              = 1'b0;
        state_nxt                  = (due_cnt_r == CNT_W'(1)) ? S_IDLE : S_TK_SEL;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rd_cnt_r     <= '0;
      now_r        <= '0;
      delay_r      <= DELAY_RESET;
      interval_r   <= INTERVAL_RESET;
      valid_r      <= '0;
      due_r        <= '0;
      due_cnt_r    <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      have_best_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      now_r        <= now_nxt;
      delay_r      <= delay_nxt;
      interval_r   <= interval_nxt;
      valid_r      <= valid_nxt;
      due_r        <= due_nxt;
      due_cnt_r    <= due_cnt_nxt;
      found_r      <= found_nxt;
      free_found_r <= free_found_nxt;
      have_best_r  <= have_best_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    match_idx_r <= match_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    best_code_r <= best_code_nxt;
    best_dev_r  <= best_dev_nxt;
    best_idx_r  <= best_idx_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

>>> src/hkrg_chk.sv
// Port-level checker for the held-key repeat generator, bound to the top level.
`include "held_key_repeat_generator_defines.svh"

module hkrg_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input hkrg_pkg::out_item_t out_item
);
  import hkrg_pkg::*;

  // A result only follows a cycle of work
  `HKRG_ASSERT_NOW(a_strobe_after_busy, out_strobe, $past(busy), "result without work")

  // An accepted item occupies the block
  `HKRG_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item left block idle")

  // Press and full results are single results
  `HKRG_ASSERT_NOW(a_single_last, out_strobe && out_item.kind != KIND_REPEAT, out_item.last,
                   "press or full result not marked last")

  // More repeats pending keep the block busy
  `HKRG_ASSERT_NOW(a_more_pending, out_strobe && !out_item.last, busy,
                   "idle before last result")

endmodule

bind held_key_repeat_generator hkrg_chk u_hkrg_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

>>> bench/tb_top.sv
// Self-checking bench for the held-key repeat generator: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
  import hkrg_pkg::*;

  localparam int HELD_KEYS   = 8;
  localparam int TIME_BITS   = 32;
  localparam int POOL_SIZE   = 12;
  localparam int PHASE_ITEMS = 72;
  localparam int SETTLE_CYC  = 3 * (HELD_KEYS + 2);
  // Longest quiet stretch of a correct run is one pass plus a long sender gap
  localparam int QUIET_LIMIT = 1000;

  localparam logic [DLY_W-1:0] PHASE_DELAY    [4] = '{8'd15, 8'd1, 8'd255, 8'd2};
  localparam logic [DLY_W-1:0] PHASE_INTERVAL [4] = '{8'd5, 8'd1, 8'd255, 8'd200};

  typedef struct {
    in_item_t  item;
    bit        typed;
    int        typed_count;
    out_item_t typed_res;
  } stim_row_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  in_item_t         in_item   = '0;
  logic             out_strobe;
  out_item_t        out_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DLY_W-1:0]     cfg_data  = '0;

  // Mirror of the key table, the tick counter and the timing registers
  logic                 held_valid   [HELD_KEYS];
  logic [CODE_W-1:0]    held_code    [HELD_KEYS];
  logic [DEV_W-1:0]     held_dev     [HELD_KEYS];
  logic [TIME_BITS-1:0] held_trigger [HELD_KEYS];
  logic [TIME_BITS-1:0] now_ticks;
  logic [DLY_W-1:0]     delay_ticks;
  logic [DLY_W-1:0]     interval_ticks;

  out_item_t         predicted_results[$];
  out_item_t         awaited_results[$];
  stim_row_t         directed_rows[$];
  logic [CODE_W-1:0] key_pool[POOL_SIZE];
  int                burst_left  = 0;
  int                mismatches  = 0;
  int                quiet_cycles = 0;

  held_key_repeat_generator #(
    .HELD_KEYS(HELD_KEYS),
    .TIME_BITS(TIME_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic out_item_t mk_res(input logic [KIND_W-1:0] kind,
                                       input logic [CODE_W-1:0] code,
                                       input logic [DEV_W-1:0] dev, input logic last);
    out_item_t r;
    r.kind = kind;
    r.out_key_code = code;
    r.out_device_id = dev;
    r.last = last;
    return r;
  endfunction

  function automatic in_item_t mk_key(input logic [CODE_W-1:0] code,
                                      input logic [DEV_W-1:0] dev, input logic down,
                                      input logic up, input logic rep, input logic dpad);
    in_item_t it;
    it.func = FUNC_KEY;
    it.key_code = code;
    it.device_id = dev;
    it.key_press = down;
    it.key_up = up;
    it.is_repeat = rep;
    it.is_dpad = dpad;
    return it;
  endfunction

  // Tick with the ignored fields all low or all high
  function automatic in_item_t mk_tick(input bit noisy);
    in_item_t it;
    it = noisy ? '1 : '0;
    it.func = FUNC_TICK;
    return it;
  endfunction

  function automatic stim_row_t mk_row(input in_item_t it, input bit typed, input int cnt,
                                       input out_item_t r);
    stim_row_t row;
    row.item = it;
    row.typed = typed;
    row.typed_count = cnt;
    row.typed_res = r;
    return row;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input stim_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  // Append one result to the prediction of the current beat
  function automatic void add_result(input out_item_t r);
    predicted_results = {predicted_results, r};
  endfunction

  function automatic int find_held(input logic [CODE_W-1:0] code);
    int hit;
    hit = -1;
    for (int i = HELD_KEYS - 1; i >= 0; i--)
      if (held_valid[i] && held_code[i] == code) hit = i;
    return hit;
  endfunction

  // Trigger has passed: wrap-safe difference is nonzero and not negative
  function automatic bit trigger_due(input logic [TIME_BITS-1:0] trig);
    logic [TIME_BITS-1:0] diff;
    diff = now_ticks - trig;
    return (diff != '0) && !diff[TIME_BITS-1];
  endfunction

  // Apply one beat to the mirrored table and collect the results it causes
  function automatic void advance_repeat_table(input in_item_t it);
    int pick;
    int slot;
    bit have_prev;
    logic [CODE_W-1:0] prev;
    predicted_results.delete();
    if (it.func == FUNC_TICK) begin
      now_ticks = now_ticks + 1'b1;
      have_prev = 1'b0;
      prev = '0;
      // Fire due entries in ascending key order, each rescheduled once
      do begin
        pick = -1;
        for (int i = 0; i < HELD_KEYS; i++) begin
          if (held_valid[i] && trigger_due(held_trigger[i]) &&
              (!have_prev || held_code[i] > prev) &&
              (pick < 0 || held_code[i] < held_code[pick]))
            pick = i;
        end
        if (pick >= 0) begin
          add_result(mk_res(KIND_REPEAT, held_code[pick], held_dev[pick], 1'b0));
          held_trigger[pick] = now_ticks + interval_ticks;
          prev = held_code[pick];
          have_prev = 1'b1;
        end
      end while (pick >= 0);
    end else if (it.key_press && !it.is_repeat && it.is_dpad &&
                 find_held(it.key_code) >= 0) begin
      // Press of a key already held: drop the whole event, release flag too
    end else begin
      if (it.key_press && !it.is_repeat && it.is_dpad) begin
        slot = -1;
        for (int i = HELD_KEYS - 1; i >= 0; i--)
          if (!held_valid[i]) slot = i;
        if (slot < 0) begin
          add_result(mk_res(KIND_FULL, it.key_code, it.device_id, 1'b0));
        end else begin
          held_valid[slot] = 1'b1;
          held_code[slot] = it.key_code;
          held_dev[slot] = it.device_id;
          held_trigger[slot] = now_ticks + delay_ticks;
          add_result(mk_res(KIND_PRESS, it.key_code, it.device_id, 1'b0));
        end
      end
      if (it.key_up) begin
        slot = find_held(it.key_code);
        if (slot >= 0) held_valid[slot] = 1'b0;
      end
    end
    // Mark the final result of the beat
    if (predicted_results.size() > 0)
      predicted_results[predicted_results.size() - 1].last = 1'b1;
  endfunction

  // Mostly press/tick/release traffic on a small key set, with some pure noise
  function automatic in_item_t random_item();
    logic [31:0] raw;
    in_item_t it;
    int roll;
    raw = $urandom;
    it = raw[$bits(in_item_t)-1:0];
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      it.func = FUNC_TICK;
    end else if (roll < 95) begin
      it.func = FUNC_KEY;
      it.key_code = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (roll < 78) begin
        it.key_press = 1'b1;
        it.key_up = ($urandom_range(0, 9) == 0);
        it.is_repeat = 1'b0;
        it.is_dpad = 1'b1;
      end else begin
        it.key_press = 1'b0;
        it.key_up = 1'b1;
      end
    end
    return it;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Drive one beat, hold it until accepted, then record what it should cause
  task automatic send_beat(input in_item_t it, input bit typed, input int typed_count,
                           input out_item_t typed_res);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    advance_repeat_table(it);
    if (typed) begin
      if (typed_count > 0) awaited_results = {awaited_results, typed_res};
    end else begin
      awaited_results = {awaited_results, predicted_results};
    end
  endtask

  // End a burst now and then with a random gap, short mostly
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 6)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // Hold off until all results are in and the block has gone idle
  task automatic settle();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_settings(input logic [DLY_W-1:0] delay, input logic [DLY_W-1:0] interval);
    cfg_valid <= 1'b1;
    cfg_index <= REG_DELAY;
    cfg_data <= delay;
    do @(posedge clk); while (!cfg_ready);
    delay_ticks = delay;
    cfg_index <= REG_INTERVAL;
    cfg_data <= interval;
    do @(posedge clk); while (!cfg_ready);
    interval_ticks = interval;
    cfg_valid <= 1'b0;
  endtask

  // Compare each result strobe with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (awaited_results.size() == 0) begin
        $error("result with none expected: kind %0d key %0d dev %0d last %0d",
               out_item.kind, out_item.out_key_code, out_item.out_device_id, out_item.last);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", want.kind, out_item.kind);
        check_field("out_key_code", want.out_key_code, out_item.out_key_code);
        check_field("out_device_id", want.out_device_id, out_item.out_device_id);
        check_field("last", want.last, out_item.last);
      end
    end
  end

  // Stop a hung run: count cycles with no beat moving on any port
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [DLY_W-1:0] delay;
    logic [DLY_W-1:0] interval;
    foreach (held_valid[i]) begin
      held_valid[i] = 1'b0;
      held_code[i] = '0;
      held_dev[i] = '0;
      held_trigger[i] = '0;
    end
    now_ticks = '0;
    delay_ticks = DELAY_RESET;
    interval_ticks = INTERVAL_RESET;

    // Directed part runs with zero delay and interval: every held key fires on every tick
    add_row(mk_row(mk_tick(1'b1), 1'b1, 0, '0));
    add_row(mk_row(mk_key(10'd0, 6'd0, 1, 0, 0, 1), 1'b1, 1,
                   mk_res(KIND_PRESS, 10'd0, 6'd0, 1'b1)));
    add_row(mk_row(mk_key(10'd1023, 6'd63, 1, 0, 0, 1), 1'b1, 1,
                   mk_res(KIND_PRESS, 10'd1023, 6'd63, 1'b1)));
    // Re-press of a held key, release flag ignored with it
    add_row(mk_row(mk_key(10'd1023, 6'd2, 1, 1, 0, 1), 1'b1, 0, '0));
    add_row(mk_row(mk_key(10'd5, 6'd1, 1, 0, 1, 1), 1'b1, 0, '0));
    add_row(mk_row(mk_key(10'd6, 6'd1, 1, 0, 0, 0), 1'b1, 0, '0));
    add_row(mk_row(mk_key(10'd7, 6'd1, 0, 1, 0, 1), 1'b1, 0, '0));
    // Non-d-pad press that carries a release: the release still drops the key
    add_row(mk_row(mk_key(10'd1023, 6'd4, 1, 1, 0, 0), 1'b1, 0, '0));
    // Press and release in one event
    add_row(mk_row(mk_key(10'd512, 6'd21, 1, 1, 0, 1), 1'b1, 1,
                   mk_res(KIND_PRESS, 10'd512, 6'd21, 1'b1)));
    add_row(mk_row(mk_tick(1'b0), 1'b0, 0, '0));
    add_row(mk_row(mk_key(10'd900, 6'd42, 1, 0, 0, 1), 1'b0, 0, '0));
    add_row(mk_row(mk_key(10'd3, 6'd13, 1, 0, 0, 1), 1'b0, 0, '0));
    add_row(mk_row(mk_key(10'd700, 6'd7, 1, 0, 0, 1), 1'b0, 0, '0));
    add_row(mk_row(mk_key(10'd40, 6'd40, 1, 0, 0, 1), 1'b0, 0, '0));
    add_row(mk_row(mk_key(10'd41, 6'd41, 1, 0, 0, 1), 1'b0, 0, '0));
    add_row(mk_row(mk_key(10'd42, 6'd42, 1, 0, 0, 1), 1'b0, 0, '0));
    add_row(mk_row(mk_key(10'd1023, 6'd32, 1, 0, 0, 1), 1'b0, 0, '0));
    // Table full: press dropped and flagged
    add_row(mk_row(mk_key(10'd1001, 6'd63, 1, 0, 0, 1), 1'b1, 1,
                   mk_res(KIND_FULL, 10'd1001, 6'd63, 1'b1)));
    add_row(mk_row(mk_tick(1'b0), 1'b0, 0, '0));
    // Release matches on key code alone
    add_row(mk_row(mk_key(10'd40, 6'd9, 0, 1, 0, 1), 1'b0, 0, '0));
    add_row(mk_row(mk_tick(1'b1), 1'b0, 0, '0));
    add_row(mk_row(mk_key(10'd40, 6'd0, 1, 1, 1, 1), 1'b0, 0, '0));
    add_row(mk_row(mk_key(10'd40, 6'd0, 1, 0, 0, 1), 1'b0, 0, '0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    write_settings(8'd0, 8'd0);
    foreach (directed_rows[r]) begin
      send_beat(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].typed_count,
                directed_rows[r].typed_res);
      pace();
    end

    // Random phases, each under its own timing and key set
    for (int p = 0; p < 5; p++) begin
      settle();
      if (p < 4) begin
        delay = PHASE_DELAY[p];
        interval = PHASE_INTERVAL[p];
      end else begin
        delay = DLY_W'($urandom_range(0, 40));
        interval = DLY_W'($urandom_range(0, 20));
      end
      write_settings(delay, interval);
      foreach (key_pool[k]) key_pool[k] = CODE_W'($urandom_range(0, 1023));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_beat(random_item(), 1'b0, 0, '0);
        // Pause mid-phase until the block has caught up
        if (n == PHASE_ITEMS / 2) settle();
        else pace();
      end
    end

    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
